// File: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;

  // register port geometry
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  // register reset values
  localparam logic [15:0] MAX_ITER_RST    = 16'd10000;
  localparam logic [31:0] REAL_ORIGIN_RST = 32'hE000_0000;
  localparam logic [30:0] REAL_STEP_RST   = 31'd1610613;
  localparam logic [31:0] IMAG_ORIGIN_RST = 32'hF000_0000;
  localparam logic [30:0] IMAG_STEP_RST   = 31'd1073742;

  // register indexes
  typedef enum logic [2:0] {
    REG_MAX_ITER    = 3'd0,
    REG_REAL_ORIGIN = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_ORIGIN = 3'd3,
    REG_IMAG_STEP   = 3'd4
  } reg_idx_t;

  // input and output transfers
  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] iteration_count;
    logic        inside_set;
  } result_t;

  // configuration register contents
  typedef struct packed {
    logic [15:0]        max_iterations;
    logic signed [31:0] real_origin;
    logic [30:0]        real_step;
    logic signed [31:0] imag_origin;
    logic [30:0]        imag_step;
  } cfg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_MUL,
    ST_UPD,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic map;
    logic seed;
    logic mul;
    logic upd;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stop;
  } dp_status_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // 16-entry colour palette, {red, green, blue}
  function automatic logic [23:0] palette_colour(input logic [3:0] k);
    logic [23:0] c;
    unique case (k)
      4'd0:  c = {8'd60,  8'd30,  8'd15};
      4'd1:  c = {8'd25,  8'd7,   8'd26};
      4'd2:  c = {8'd9,   8'd1,   8'd47};
      4'd3:  c = {8'd4,   8'd4,   8'd73};
      4'd4:  c = {8'd0,   8'd7,   8'd100};
      4'd5:  c = {8'd12,  8'd44,  8'd138};
      4'd6:  c = {8'd24,  8'd82,  8'd177};
      4'd7:  c = {8'd57,  8'd125, 8'd209};
      4'd8:  c = {8'd134, 8'd181, 8'd229};
      4'd9:  c = {8'd211, 8'd236, 8'd248};
      4'd10: c = {8'd241, 8'd233, 8'd191};
      4'd11: c = {8'd248, 8'd201, 8'd95};
      4'd12: c = {8'd255, 8'd170, 8'd0};
      4'd13: c = {8'd204, 8'd128, 8'd0};
      4'd14: c = {8'd153, 8'd87,  8'd0};
      4'd15: c = {8'd106, 8'd52,  8'd3};
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/mbe_regs.sv
module mbe_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [mbe_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output mbe_pkg::cfg_t                      cfg
);
  import mbe_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations <= MAX_ITER_RST;
      cfg.real_origin    <= REAL_ORIGIN_RST;
      cfg.real_step      <= REAL_STEP_RST;
      cfg.imag_origin    <= IMAG_ORIGIN_RST;
      cfg.imag_step      <= IMAG_STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_ITER:    cfg.max_iterations <= pwdata[15:0];
        REG_REAL_ORIGIN: cfg.real_origin    <= pwdata[31:0];
        REG_REAL_STEP:   cfg.real_step      <= pwdata[30:0];
        REG_IMAG_ORIGIN: cfg.imag_origin    <= pwdata[31:0];
        REG_IMAG_STEP:   cfg.imag_step      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_MAX_ITER:    prdata = CFG_DATA_BITS'(cfg.max_iterations);
      REG_REAL_ORIGIN: prdata = CFG_DATA_BITS'(cfg.real_origin);
      REG_REAL_STEP:   prdata = CFG_DATA_BITS'(cfg.real_step);
      REG_IMAG_ORIGIN: prdata = CFG_DATA_BITS'(cfg.imag_origin);
      REG_IMAG_STEP:   prdata = CFG_DATA_BITS'(cfg.imag_step);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/mbe_ctrl.sv
module mbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  mbe_pkg::dp_status_t status,
  output mbe_pkg::dp_cmd_t    cmd
);
  import mbe_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    pixel_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          cmd.map    = 1'b1;
          state_next = ST_ORIGIN;
        end
      end
      ST_ORIGIN: begin
        cmd.seed   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (status.stop) begin
          state_next = ST_FINISH;
        end else begin
          cmd.upd    = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!result_valid || !result_stall) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register fill and drain
  always_comb begin
    if (cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

endmodule

// File: hw/rtl/mbe_dp.sv
module mbe_dp #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  mbe_pkg::pixel_t     pixel,
  input  mbe_pkg::cfg_t       cfg,
  input  mbe_pkg::dp_cmd_t    cmd,
  output mbe_pkg::dp_status_t status,
  output mbe_pkg::result_t    result
);
  import mbe_pkg::*;

  localparam int PW = COORD_BITS + 31;
  localparam int CW = COORD_BITS + 33;
  localparam int SW = 64 - FRAC_BITS;
  localparam logic [65:0] LIMIT = 66'(4) << FRAC_BITS;

  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [PW-1:0]         re_off;
  logic [PW-1:0]         im_off;
  logic signed [CW-1:0]  c_re;
  logic signed [CW-1:0]  c_im;
  logic signed [31:0]    zr;
  logic signed [31:0]    zi;
  logic signed [63:0]    p_rr;
  logic signed [63:0]    p_ii;
  logic signed [63:0]    p_ri;
  logic [15:0]           count;
  logic [SW-1:0]         sq_re;
  logic [SW-1:0]         sq_im;
  logic [SW:0]           sq_sum;
  logic signed [63:0]    cross_term;
  logic signed [63:0]    nr;
  logic signed [63:0]    ni;
  logic                  escaped;
  logic                  in_set;
  logic [23:0]           colour;

  assign col = COORD_BITS'(pixel.pixel_col);
  assign row = COORD_BITS'(pixel.pixel_row);

  // point offsets from the pixel position
  always_ff @(posedge clk) begin
    if (cmd.map) begin
      re_off <= PW'(col) * PW'(cfg.real_step);
      im_off <= PW'(row) * PW'(cfg.imag_step);
    end
  end

  // point c and iteration state
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      c_re  <= CW'($signed(cfg.real_origin)) + CW'(re_off);
      c_im  <= CW'($signed(cfg.imag_origin)) + CW'(im_off);
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.upd) begin
      zr    <= sat32(nr);
      zi    <= sat32(ni);
      count <= count + 16'd1;
    end
  end

  // products of the current z
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_rr <= 64'(zr) * 64'(zr);
      p_ii <= 64'(zi) * 64'(zi);
      p_ri <= 64'(zr) * 64'(zi);
    end
  end

  // escape test and next z
  always_comb begin
    sq_re      = p_rr[63:FRAC_BITS];
    sq_im      = p_ii[63:FRAC_BITS];
    sq_sum     = {1'b0, sq_re} + {1'b0, sq_im};
    escaped    = 66'(sq_sum) > LIMIT;
    cross_term = p_ri >>> (FRAC_BITS - 1);
    nr         = $signed(64'(sq_re)) - $signed(64'(sq_im)) + 64'(c_re);
    ni         = cross_term + 64'(c_im);
  end

  assign in_set      = count >= cfg.max_iterations;
  assign status.stop = escaped || in_set;
  assign colour      = in_set ? 24'd0 : palette_colour(count[3:0]);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.red             <= colour[23:16];
      result.green           <= colour[15:8];
      result.blue            <= colour[7:0];
      result.iteration_count <= count;
      result.inside_set      <= in_set;
    end
  end

endmodule

// File: hw/rtl/mandelbrot_escape_time_pixel_top.sv
// channel  | handshake                   | payload
// pixel    | pixel_valid / pixel_stall   | pixel (pixel_row, pixel_col)
// result   | result_valid / result_stall | result (rgb, iteration_count, inside_set)
// config   | psel, penable, pwrite       | paddr, pwdata, prdata
//
// after a transfer in, the controller steps through map, seed, a multiply step and an
// update step per iteration, and finish; result valid rises once the result is registered.
// the next pixel can be taken when the controller is back in idle.
// rst is synchronous: the controller returns to idle and the configuration registers take defaults.
// a pixel is taken only in idle; a finished result waits in the output register
// while the next pixel is taken, and the controller holds if that register is full.
module mandelbrot_escape_time_pixel_top #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  mbe_pkg::pixel_t                    pixel,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mbe_pkg::result_t                   result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [mbe_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [mbe_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import mbe_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers
  mbe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  mbe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic
  mbe_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .pixel  (pixel),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // a transfer in starts work, so the next cycle is busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> pixel_stall)
    else $error("pixel taken while previous item still in progress");

  // inside points are black
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.inside_set) |->
      (result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0))
    else $error("inside point with non-black colour");

  // escaped points carry a palette colour, none of which is black
  a_escaped_colour: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.inside_set) |->
      (result.red != 8'd0 || result.green != 8'd0 || result.blue != 8'd0))
    else $error("escaped point with black colour");

endmodule
